@@ hw/rtl/avhf_pkg.sv @@
package avhf_pkg;

  localparam int DIST_W     = 16;
  localparam int VEL_W      = 32;
  localparam int NUM_W      = 36;
  localparam int CNT_W      = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int RUN_W      = 8;

  localparam logic [19:0]       MICROS_PER_SEC = 20'd1000000;
  localparam logic [RUN_W-1:0]  RUN_MAX        = 8'd255;
  localparam logic [NUM_W-1:0]  Q_POS_MAX      = 36'h0_7FFF_FFFF;
  localparam logic [NUM_W-1:0]  Q_NEG_MAX      = 36'h0_8000_0000;
  localparam logic [VEL_W-1:0]  VEL_MAX        = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0]  VEL_MIN        = 32'h8000_0000;

  typedef enum logic [1:0] {
    HZ_NONE   = 2'd0,
    HZ_STABLE = 2'd1,
    HZ_APPR   = 2'd2,
    HZ_RECEDE = 2'd3
  } hazard_t;

  typedef enum logic [1:0] {
    REG_ZONE_MAX  = 2'd0,
    REG_SPEED     = 2'd1,
    REG_CONFIRM   = 2'd2,
    REG_INVALID   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

@@ hw/rtl/avhf_div.sv @@
module avhf_div import avhf_pkg::*; #(
  parameter int DIV_W = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DIV_W-1:0] denom,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;

  logic [DIV_W:0]   trial;
  logic [DIV_W+1:0] diff;
  logic             ge;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = ~diff[DIV_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = numer;
      den_nxt  = denom;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

@@ hw/rtl/approach_velocity_hazard_filter.sv @@
// Channel  Direction  Handshake                  Payload
// in_      sink       in_tvalid / in_tready      distance, timestamp; action, valid flag
// out_     source     out_tvalid / out_tready    velocity, last distance; state, alert
// cfg_     APB slave  psel, penable, pready = 1  four control registers at 4*i
//
// A sample with a usable history passes through S_PREP, S_DIV and S_FIN, and in S_DIV the
// one-bit-per-cycle restoring divider works over 36 bits. A cleared or rejected sample,
// or one without an earlier sample or a later timestamp, goes from S_PREP straight to
// S_FIN. One sample is in work at a time and in_tready is high only when idle. A stalled
// output holds the block at its final step.
// Reset is synchronous and active low and restores the register defaults.
module approach_velocity_hazard_filter import avhf_pkg::*; #(
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] distance_mm, [TIME_BITS+15:16] time_us, zero padding above
  input  logic [((DIST_W+TIME_BITS+7)/8)*8-1:0] in_tdata,
  // [0] action, [1] sample_valid
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] velocity, [47:32] last_distance_mm
  output logic [47:0]           out_tdata,
  // [1:0] hazard_state, [2] alert
  output logic [2:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  state_t state_r, state_nxt;

  logic [DIST_W-1:0]    zone_r, speed_r, marker_r;
  logic [RUN_W-1:0]     confirm_r;

  logic                 act_r, vld_r;
  logic [DIST_W-1:0]    mm_r;
  logic [TIME_BITS-1:0] now_r;

  logic [DIST_W-1:0]    prev_dist_r;
  logic [TIME_BITS-1:0] prev_time_r;
  logic                 prev_present_r;
  logic [RUN_W-1:0]     run_r;

  logic                 rej_r, zero_r, neg_r;

  logic                 out_valid_r;
  hazard_t              out_st_r;
  logic [VEL_W-1:0]     out_v_r;
  logic [DIST_W-1:0]    out_last_r;

  logic                 in_acc, cfg_wr, fin_go;
  logic                 rej_c, zero_c;
  logic [TIME_BITS:0]   dt_full;
  logic [DIST_W:0]      ddiff;
  logic [DIST_W-1:0]    mag;
  logic [NUM_W-1:0]     numer;
  logic                 div_start, div_done;
  logic [NUM_W-1:0]     quot;

  logic [VEL_W-1:0]     vel;
  logic signed [VEL_W:0] v_ext, thr_pos, thr_neg;
  logic [RUN_W-1:0]     run_inc;
  hazard_t              st;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r    <= 16'd2000;
      speed_r   <= 16'd100;
      confirm_r <= 8'd3;
      marker_r  <= 16'hFFFF;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_ZONE_MAX: zone_r    <= cfg_pwdata[DIST_W-1:0];
        REG_SPEED:    speed_r   <= cfg_pwdata[DIST_W-1:0];
        REG_CONFIRM:  confirm_r <= cfg_pwdata[RUN_W-1:0];
        REG_INVALID:  marker_r  <= cfg_pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_ZONE_MAX: cfg_prdata = CFG_DATA_W'(zone_r);
      REG_SPEED:    cfg_prdata = CFG_DATA_W'(speed_r);
      REG_CONFIRM:  cfg_prdata = CFG_DATA_W'(confirm_r);
      REG_INVALID:  cfg_prdata = CFG_DATA_W'(marker_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser[0];
      vld_r <= in_tuser[1];
      mm_r  <= in_tdata[DIST_W-1:0];
      now_r <= in_tdata[DIST_W+TIME_BITS-1:DIST_W];
    end
  end

  assign rej_c   = act_r | ~vld_r | (mm_r == marker_r) | (mm_r > zone_r);
  assign dt_full = {1'b0, now_r} - {1'b0, prev_time_r};
  assign zero_c  = ~prev_present_r | dt_full[TIME_BITS] | (dt_full[TIME_BITS-1:0] == '0);
  assign ddiff   = {1'b0, mm_r} - {1'b0, prev_dist_r};
  assign mag     = ddiff[DIST_W] ? (~ddiff[DIST_W-1:0] + 1'b1) : ddiff[DIST_W-1:0];
  assign numer   = NUM_W'(mag) * NUM_W'(MICROS_PER_SEC);

  assign div_start = (state_r == S_PREP) & ~rej_c & ~zero_c;

  avhf_div #(.DIV_W(TIME_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (dt_full[TIME_BITS-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      rej_r  <= rej_c;
      zero_r <= zero_c;
      neg_r  <= ddiff[DIST_W];
    end
  end

  always_comb begin
    if (zero_r) begin
      vel = '0;
    end else if (neg_r) begin
      vel = (quot > Q_NEG_MAX) ? VEL_MIN : (~quot[VEL_W-1:0] + 1'b1);
    end else begin
      vel = (quot > Q_POS_MAX) ? VEL_MAX : quot[VEL_W-1:0];
    end
  end

  assign v_ext   = {vel[VEL_W-1], vel};
  assign thr_pos = $signed({17'd0, speed_r});
  assign thr_neg = -thr_pos;
  assign run_inc = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;

  always_comb begin
    if (v_ext < thr_neg) begin
      st = (run_inc >= confirm_r) ? HZ_APPR : HZ_STABLE;
    end else if (v_ext > thr_pos) begin
      st = HZ_RECEDE;
    end else begin
      st = prev_present_r ? HZ_STABLE : HZ_NONE;
    end
  end

  assign fin_go = (state_r == S_FIN) & (~out_valid_r | out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_PREP;
      S_PREP: state_nxt = div_start ? S_DIV : S_FIN;
      S_DIV:  if (div_done) state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      prev_present_r <= 1'b0;
      run_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (rej_r) begin
          prev_present_r <= 1'b0;
          run_r          <= '0;
        end else begin
          prev_present_r <= 1'b1;
          run_r          <= (v_ext < thr_neg) ? run_inc : '0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (rej_r) begin
        out_st_r   <= HZ_NONE;
        out_v_r    <= '0;
        out_last_r <= marker_r;
      end else begin
        out_st_r    <= st;
        out_v_r     <= vel;
        out_last_r  <= mm_r;
        prev_dist_r <= mm_r;
        prev_time_r <= now_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_last_r, out_v_r};
  assign out_tuser  = {(out_st_r == HZ_APPR), out_st_r};

`ifndef SYNTHESIS
  a_acc_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_PREP))
    else $error("accepted word did not enter preparation");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide phase");

  a_none_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == HZ_NONE)) |-> (out_v_r == '0))
    else $error("no-hazard result carries a nonzero velocity");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("final step did not present a result word");
`endif

endmodule
